@@ sv/priority_ordered_task_table_defines.svh @@
// assertion macros for the priority ordered task table
// expects clock and reset in the scope of the module that uses them
`ifndef PRIORITY_ORDERED_TASK_TABLE_DEFINES_SVH
`define PRIORITY_ORDERED_TASK_TABLE_DEFINES_SVH

// condition that must hold at every edge out of reset
`define POTT_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// same-cycle implication
`define POTT_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ sv/pott_pkg.sv @@
// shared constants, codes and types of the priority ordered task table
// no dependencies
package pott_pkg;

   localparam int SLOT_COUNT_DEF = 16;

   localparam int KIND_W      = 2;
   localparam int PRIO_W      = 8;
   localparam int REQ_SLOT_W  = 4;
   localparam int LINK_OUT_W  = 5;
   localparam int COUNT_OUT_W = 5;

   localparam logic [PRIO_W-1:0] PRIO_RESET = 8'hFF;

   localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_EV,
      ST_NEW_WR,
      ST_PATCH_RD,
      ST_PATCH_WR,
      ST_ENT_RD,
      ST_ENT_EV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [REQ_SLOT_W-1:0] slot_id;
      logic                  create_failed;
      logic                  entry_active;
      logic [PRIO_W-1:0]     entry_priority;
      logic [LINK_OUT_W-1:0] entry_prev;
      logic [LINK_OUT_W-1:0] entry_next;
   } entry_res_type;

   typedef struct packed {
      entry_res_type          entry;
      logic [LINK_OUT_W-1:0]  head_slot;
      logic [COUNT_OUT_W-1:0] active_count;
   } rsp_type;

endpackage

@@ sv/pott_ram.sv @@
// generic single port ram, one access a cycle, registered read data
// no dependencies
module pott_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rdata = rd_data_ff;

endmodule

@@ sv/priority_ordered_task_table.sv @@
// priority ordered task table: slot records in one ram, list walked by a sequencer
// depends on pott_pkg, pott_ram and priority_ordered_task_table_defines.svh
//
//   channel | ports  | beat
//   --------+--------+--------------------------------------------------
//   input   | req_*  | kind, priority_req, slot
//   result  | rsp_*  | slot_id, flags, entry fields, head_slot, count
//
// one item at a time, paced by the single ram port: each walk step over a linked
// entry is a read plus its evaluation, each neighbour fix a read then a write.
// reset is synchronous; the ram needs no clearing, per-slot written bits stand
// in for its reset contents. a new item is taken while a result waits; a held
// result stalls the sequencer at its last step only.
`include "priority_ordered_task_table_defines.svh"

module priority_ordered_task_table
   import pott_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [PRIO_W-1:0]      req_priority_req,
   input  logic [REQ_SLOT_W-1:0]  req_slot,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [REQ_SLOT_W-1:0]  rsp_slot_id,
   output logic                   rsp_create_failed,
   output logic                   rsp_entry_active,
   output logic [PRIO_W-1:0]      rsp_entry_priority,
   output logic [LINK_OUT_W-1:0]  rsp_entry_prev,
   output logic [LINK_OUT_W-1:0]  rsp_entry_next,
   output logic [LINK_OUT_W-1:0]  rsp_head_slot,
   output logic [COUNT_OUT_W-1:0] rsp_active_count
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int LINK_W = $clog2(SLOT_COUNT + 2);
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

   localparam logic [LINK_W-1:0] HEAD_MARK = LINK_W'(SLOT_COUNT);
   localparam logic [LINK_W-1:0] TAIL_MARK = LINK_W'(SLOT_COUNT + 1);

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [LINK_W-1:0] prev;
      logic [LINK_W-1:0] nxt;
   } rec_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic              is_next;
      logic [LINK_W-1:0] val;
   } patch_type;

   localparam int REC_W = $bits(rec_type);

   function automatic rec_type reset_rec(input logic [SLOT_W-1:0] s);
      rec_type r;
      r.prio = PRIO_RESET;
      r.prev = (s == '0) ? HEAD_MARK : LINK_W'(s);
      r.nxt  = (32'(s) == SLOT_COUNT - 1) ? TAIL_MARK : LINK_W'(32'(s) + 1);
      return r;
   endfunction

   function automatic logic link_ok(input logic [LINK_W-1:0] l);
      return 32'(l) < SLOT_COUNT;
   endfunction

   function automatic logic [SLOT_W-1:0] to_slot(input logic [LINK_W-1:0] l);
      return SLOT_W'(l);
   endfunction

   state_type             state_ff, state_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [PRIO_W-1:0]     prio_ff, prio_in;
   logic [REQ_SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0]     cur_ff, cur_in;
   logic [SLOT_W-1:0]     nw_ff, nw_in;
   rec_type               nw_rec_ff, nw_rec_in;
   logic                  head_new_ff, head_new_in;
   patch_type             patch_ff [2];
   patch_type             patch_in [2];
   logic                  patch_idx_ff, patch_idx_in;
   logic [SLOT_COUNT-1:0] active_ff, active_in;
   logic [SLOT_COUNT-1:0] written_ff, written_in;
   logic [LINK_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   entry_res_type         res_ff, res_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  ram_we;
   logic [SLOT_W-1:0]     ram_addr;
   rec_type               ram_wdata;
   logic [REC_W-1:0]      ram_rdata;
   rec_type               eff_rec;
   rec_type               patched;
   patch_type             cur_patch;
   logic [SLOT_W-1:0]     slot_idx;
   logic [SLOT_W-1:0]     free_slot;
   logic                  free_any;
   logic                  p_ok;
   logic                  n_ok;

   pott_ram #(
      .WIDTH(REC_W),
      .DEPTH(SLOT_COUNT)
   ) u_rec_ram (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign slot_idx  = SLOT_W'(slot_ff);
   assign cur_patch = patch_ff[patch_idx_ff];
   // a never written slot still holds its reset record
   assign eff_rec   = written_ff[ram_addr] ? rec_type'(ram_rdata) : reset_rec(ram_addr);
   assign free_any  = ~&active_ff;

   // lowest free slot
   always_comb begin
      free_slot = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
   end

   // ram address depends on registered state only, held over each read and its use
   always_comb begin
      unique case (state_ff)
         ST_WALK_RD, ST_WALK_EV:   ram_addr = cur_ff;
         ST_PATCH_RD, ST_PATCH_WR: ram_addr = cur_patch.slot;
         ST_ENT_RD, ST_ENT_EV:     ram_addr = slot_idx;
         default:                  ram_addr = nw_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      prio_in      = prio_ff;
      slot_in      = slot_ff;
      cur_in       = cur_ff;
      nw_in        = nw_ff;
      nw_rec_in    = nw_rec_ff;
      head_new_in  = head_new_ff;
      patch_in[0]  = patch_ff[0];
      patch_in[1]  = patch_ff[1];
      patch_idx_in = patch_idx_ff;
      active_in    = active_ff;
      written_in   = written_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == ST_IDLE);
      ram_we       = 1'b0;
      ram_wdata    = nw_rec_ff;
      patched      = eff_rec;
      p_ok         = link_ok(eff_rec.prev);
      n_ok         = link_ok(eff_rec.nxt);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in        = req_kind;
               prio_in        = req_priority_req;
               slot_in        = req_slot;
               patch_in[0].en = 1'b0;
               patch_in[1].en = 1'b0;
               head_new_in    = 1'b0;
               if (req_kind == KIND_CREATE) begin
                  if (!free_any) begin
                     res_in               = '0;
                     res_in.create_failed = 1'b1;
                     state_in             = ST_DONE;
                  end else begin
                     nw_in = free_slot;
                     if (!link_ok(head_ff)) begin
                        nw_rec_in   = '{req_priority_req, HEAD_MARK, TAIL_MARK};
                        head_new_in = 1'b1;
                        state_in    = ST_NEW_WR;
                     end else begin
                        cur_in   = to_slot(head_ff);
                        state_in = ST_WALK_RD;
                     end
                  end
               end else if (32'(req_slot) >= SLOT_COUNT) begin
                  res_in         = '0;
                  res_in.slot_id = req_slot;
                  state_in       = ST_DONE;
               end else begin
                  state_in = ST_ENT_RD;
               end
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_EV;
         end
         ST_WALK_EV: begin
            // strictly greater keeps equal priorities in arrival order
            if (prio_ff < eff_rec.prio) begin
               nw_rec_in.prio = prio_ff;
               nw_rec_in.prev = p_ok ? eff_rec.prev : HEAD_MARK;
               nw_rec_in.nxt  = LINK_W'(cur_ff);
               patch_in[0]    = '{1'b1, cur_ff, 1'b0, LINK_W'(nw_ff)};
               patch_in[1]    = '{p_ok, to_slot(eff_rec.prev), 1'b1, LINK_W'(nw_ff)};
               head_new_in    = !p_ok;
               state_in       = ST_NEW_WR;
            end else if (!n_ok) begin
               nw_rec_in   = '{prio_ff, LINK_W'(cur_ff), TAIL_MARK};
               patch_in[0] = '{1'b1, cur_ff, 1'b1, LINK_W'(nw_ff)};
               state_in    = ST_NEW_WR;
            end else begin
               cur_in   = to_slot(eff_rec.nxt);
               state_in = ST_WALK_RD;
            end
         end
         ST_NEW_WR: begin
            ram_we            = 1'b1;
            ram_wdata         = nw_rec_ff;
            written_in[nw_ff] = 1'b1;
            active_in[nw_ff]  = 1'b1;
            count_in          = count_ff + 1'b1;
            if (head_new_ff) begin
               head_in = LINK_W'(nw_ff);
            end
            res_in.slot_id        = REQ_SLOT_W'(nw_ff);
            res_in.create_failed  = 1'b0;
            res_in.entry_active   = 1'b1;
            res_in.entry_priority = nw_rec_ff.prio;
            res_in.entry_prev     = LINK_OUT_W'(nw_rec_ff.prev);
            res_in.entry_next     = LINK_OUT_W'(nw_rec_ff.nxt);
            if (patch_ff[0].en) begin
               patch_idx_in = 1'b0;
               state_in     = ST_PATCH_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PATCH_RD: begin
            state_in = ST_PATCH_WR;
         end
         ST_PATCH_WR: begin
            if (cur_patch.is_next) begin
               patched.nxt = cur_patch.val;
            end else begin
               patched.prev = cur_patch.val;
            end
            ram_we                     = 1'b1;
            ram_wdata                  = patched;
            written_in[cur_patch.slot] = 1'b1;
            if (!patch_idx_ff && patch_ff[1].en) begin
               patch_idx_in = 1'b1;
               state_in     = ST_PATCH_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ENT_RD: begin
            state_in = ST_ENT_EV;
         end
         ST_ENT_EV: begin
            res_in.slot_id        = slot_ff;
            res_in.create_failed  = 1'b0;
            res_in.entry_active   = active_ff[slot_idx];
            res_in.entry_priority = eff_rec.prio;
            res_in.entry_prev     = LINK_OUT_W'(eff_rec.prev);
            res_in.entry_next     = LINK_OUT_W'(eff_rec.nxt);
            state_in              = ST_DONE;
            if (kind_ff == KIND_DESTROY && active_ff[slot_idx]) begin
               res_in.entry_active = 1'b0;
               active_in[slot_idx] = 1'b0;
               count_in            = count_ff - 1'b1;
               patch_in[0] = '{p_ok, to_slot(eff_rec.prev), 1'b1,
                               n_ok ? eff_rec.nxt : TAIL_MARK};
               patch_in[1] = '{n_ok, to_slot(eff_rec.nxt), 1'b0,
                               p_ok ? eff_rec.prev : HEAD_MARK};
               // removing the head hands it to the follower
               if (!p_ok) begin
                  head_in = n_ok ? eff_rec.nxt : HEAD_MARK;
               end
               if (p_ok) begin
                  patch_idx_in = 1'b0;
                  state_in     = ST_PATCH_RD;
               end else if (n_ok) begin
                  patch_idx_in = 1'b1;
                  state_in     = ST_PATCH_RD;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.entry        = res_ff;
               rsp_in.head_slot    = LINK_OUT_W'(head_ff);
               rsp_in.active_count = COUNT_OUT_W'(count_ff);
               state_in            = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         written_ff   <= '0;
         head_ff      <= HEAD_MARK;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         head_new_ff  <= 1'b0;
         patch_idx_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         written_ff   <= written_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         head_new_ff  <= head_new_in;
         patch_idx_ff <= patch_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      prio_ff     <= prio_in;
      slot_ff     <= slot_in;
      cur_ff      <= cur_in;
      nw_ff       <= nw_in;
      nw_rec_ff   <= nw_rec_in;
      patch_ff[0] <= patch_in[0];
      patch_ff[1] <= patch_in[1];
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot_id        = rsp_ff.entry.slot_id;
   assign rsp_create_failed  = rsp_ff.entry.create_failed;
   assign rsp_entry_active   = rsp_ff.entry.entry_active;
   assign rsp_entry_priority = rsp_ff.entry.entry_priority;
   assign rsp_entry_prev     = rsp_ff.entry.entry_prev;
   assign rsp_entry_next     = rsp_ff.entry.entry_next;
   assign rsp_head_slot      = rsp_ff.head_slot;
   assign rsp_active_count   = rsp_ff.active_count;

   `POTT_ASSERT_ALWAYS(a_count_matches, 32'(count_ff) == $countones(active_ff), "count drift")
   `POTT_ASSERT_ALWAYS(a_head_iff_busy, (head_ff == HEAD_MARK) == (count_ff == '0), "head mismatch")
   `POTT_ASSERT_ALWAYS(a_active_written, (active_ff & ~written_ff) == '0, "active slot unwritten")
   `POTT_ASSERT_IMPLY(a_new_slot_free, state_ff == ST_NEW_WR, !active_ff[nw_ff], "slot reused")
   `POTT_ASSERT_IMPLY(a_patch_rmw, state_ff == ST_PATCH_WR, $past(state_ff) == ST_PATCH_RD, "patch order")

endmodule

@@ verif/priority_ordered_task_table_tb.sv @@
// testbench for the priority ordered task table: random and directed create, destroy and read
// beats, each result checked against a behavioural copy of the slot list
// depends on pott_pkg and the priority_ordered_task_table rtl
import pott_pkg::*;

localparam int TABLE_SLOTS = SLOT_COUNT_DEF;
localparam int HEAD_MARK   = TABLE_SLOTS;
localparam int TAIL_MARK   = TABLE_SLOTS + 1;

class task_table_scoreboard;
   bit                    active[TABLE_SLOTS];
   logic [PRIO_W-1:0]     prio[TABLE_SLOTS];
   logic [LINK_OUT_W-1:0] prev_link[TABLE_SLOTS];
   logic [LINK_OUT_W-1:0] next_link[TABLE_SLOTS];
   rsp_type               expected_results[$];
   int                    errors;

   function new();
      errors = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         active[i]    = 1'b0;
         prio[i]      = PRIO_RESET;
         prev_link[i] = LINK_OUT_W'(i);
         next_link[i] = LINK_OUT_W'(i + 1);
      end
      prev_link[0]             = LINK_OUT_W'(HEAD_MARK);
      next_link[TABLE_SLOTS-1] = LINK_OUT_W'(TAIL_MARK);
   endfunction

   function int find_head();
      for (int i = 0; i < TABLE_SLOTS; i++)
         if (active[i] && prev_link[i] == HEAD_MARK) return i;
      return TABLE_SLOTS;
   endfunction

   function int active_total();
      int c;
      c = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) c += active[i];
      return c;
   endfunction

   function int pending();
      return expected_results.size();
   endfunction

   function int random_active_slot();
      int s;
      if (active_total() == 0) return $urandom_range(0, TABLE_SLOTS - 1);
      do s = $urandom_range(0, TABLE_SLOTS - 1); while (!active[s]);
      return s;
   endfunction

   // insert before the first entry of strictly greater priority, walk bounded
   function void link_entry(int nw);
      int cur;
      int p;
      int nx;
      cur = find_head();
      if (cur >= TABLE_SLOTS) begin
         prev_link[nw] = LINK_OUT_W'(HEAD_MARK);
         next_link[nw] = LINK_OUT_W'(TAIL_MARK);
         return;
      end
      for (int steps = 0; steps < TABLE_SLOTS; steps++) begin
         if (prio[nw] < prio[cur]) begin
            p = prev_link[cur];
            prev_link[nw] = LINK_OUT_W'(p < TABLE_SLOTS ? p : HEAD_MARK);
            next_link[nw] = LINK_OUT_W'(cur);
            if (p < TABLE_SLOTS) next_link[p] = LINK_OUT_W'(nw);
            prev_link[cur] = LINK_OUT_W'(nw);
            return;
         end
         nx = next_link[cur];
         if (nx >= TABLE_SLOTS) break;
         cur = nx;
      end
      prev_link[nw]  = LINK_OUT_W'(cur);
      next_link[nw]  = LINK_OUT_W'(TAIL_MARK);
      next_link[cur] = LINK_OUT_W'(nw);
   endfunction

   function void unlink_entry(int s);
      int p;
      int n;
      p = prev_link[s];
      n = next_link[s];
      active[s] = 1'b0;
      if (p >= TABLE_SLOTS) begin
         if (n < TABLE_SLOTS) prev_link[n] = LINK_OUT_W'(HEAD_MARK);
      end else if (n >= TABLE_SLOTS) begin
         next_link[p] = LINK_OUT_W'(TAIL_MARK);
      end else begin
         next_link[p] = LINK_OUT_W'(n);
         prev_link[n] = LINK_OUT_W'(p);
      end
   endfunction

   // apply one accepted request beat and queue the response it causes
   function void note_request(logic [KIND_W-1:0] kind, logic [PRIO_W-1:0] prio_in,
                              logic [REQ_SLOT_W-1:0] slot_in);
      int      addr;
      bit      failed;
      bit      addr_ok;
      rsp_type want;
      addr   = slot_in;
      failed = 1'b0;
      if (kind == KIND_CREATE) begin
         addr = TABLE_SLOTS;
         for (int i = 0; i < TABLE_SLOTS; i++)
            if (!active[i]) begin
               addr = i;
               break;
            end
         if (addr >= TABLE_SLOTS) begin
            failed = 1'b1;
         end else begin
            prio[addr] = prio_in;
            link_entry(addr);
            active[addr] = 1'b1;
         end
      end else if (kind == KIND_DESTROY) begin
         if (addr < TABLE_SLOTS && active[addr]) unlink_entry(addr);
      end
      addr_ok = !failed && addr < TABLE_SLOTS;
      want.entry.slot_id        = failed ? '0 : REQ_SLOT_W'(addr);
      want.entry.create_failed  = failed;
      want.entry.entry_active   = addr_ok ? active[addr] : 1'b0;
      want.entry.entry_priority = addr_ok ? prio[addr] : '0;
      want.entry.entry_prev     = addr_ok ? prev_link[addr] : '0;
      want.entry.entry_next     = addr_ok ? next_link[addr] : '0;
      want.head_slot            = LINK_OUT_W'(find_head());
      want.active_count         = COUNT_OUT_W'(active_total());
      expected_results.push_back(want);
   endfunction

   function void report(string what, int want, int got);
      errors++;
      if (errors <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         report("unexpected response beat", 0, 1);
         return;
      end
      want = expected_results.pop_front();
      if (got.entry.slot_id != want.entry.slot_id)
         report("slot_id", want.entry.slot_id, got.entry.slot_id);
      if (got.entry.create_failed != want.entry.create_failed)
         report("create_failed", want.entry.create_failed, got.entry.create_failed);
      if (got.entry.entry_active != want.entry.entry_active)
         report("entry_active", want.entry.entry_active, got.entry.entry_active);
      if (got.entry.entry_priority != want.entry.entry_priority)
         report("entry_priority", want.entry.entry_priority, got.entry.entry_priority);
      if (got.entry.entry_prev != want.entry.entry_prev)
         report("entry_prev", want.entry.entry_prev, got.entry.entry_prev);
      if (got.entry.entry_next != want.entry.entry_next)
         report("entry_next", want.entry.entry_next, got.entry.entry_next);
      if (got.head_slot != want.head_slot)
         report("head_slot", want.head_slot, got.head_slot);
      if (got.active_count != want.active_count)
         report("active_count", want.active_count, got.active_count);
   endfunction
endclass

module priority_ordered_task_table_tb;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 1100;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 60;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [KIND_W-1:0]      req_kind;
   logic [PRIO_W-1:0]      req_priority_req;
   logic [REQ_SLOT_W-1:0]  req_slot;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [REQ_SLOT_W-1:0]  rsp_slot_id;
   logic                   rsp_create_failed;
   logic                   rsp_entry_active;
   logic [PRIO_W-1:0]      rsp_entry_priority;
   logic [LINK_OUT_W-1:0]  rsp_entry_prev;
   logic [LINK_OUT_W-1:0]  rsp_entry_next;
   logic [LINK_OUT_W-1:0]  rsp_head_slot;
   logic [COUNT_OUT_W-1:0] rsp_active_count;

   task_table_scoreboard sb;
   int      cycle_count;
   int      items_sent;
   int      burst_left;
   int      stall_timer;
   int      stall_mode;
   rsp_type rsp_seen;

   priority_ordered_task_table u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("priority_ordered_task_table_tb: done, errors");
         $finish;
      end
   end

   // response side: check the beat taken at this edge, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen.entry.slot_id        = rsp_slot_id;
         rsp_seen.entry.create_failed  = rsp_create_failed;
         rsp_seen.entry.entry_active   = rsp_entry_active;
         rsp_seen.entry.entry_priority = rsp_entry_priority;
         rsp_seen.entry.entry_prev     = rsp_entry_prev;
         rsp_seen.entry.entry_next     = rsp_entry_next;
         rsp_seen.head_slot            = rsp_head_slot;
         rsp_seen.active_count         = rsp_active_count;
         sb.check_response(rsp_seen);
      end
      if (stall_timer == 0) begin
         stall_mode  = $urandom_range(0, 3);
         stall_timer = $urandom_range(20, 200);
      end else begin
         stall_timer--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (cycle_count % 5) != 0;
         default: rsp_ready <= (cycle_count % 32) >= 20;
      endcase
   end

   // hold the beat until taken; leave valid high when the burst carries on
   task automatic issue(logic [KIND_W-1:0] kind, logic [PRIO_W-1:0] prio_in,
                        logic [REQ_SLOT_W-1:0] slot_in);
      int gap;
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_priority_req <= prio_in;
      req_slot         <= slot_in;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, prio_in, slot_in);
      items_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = $urandom_range(0, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [PRIO_W-1:0] pick_priority();
      case ($urandom_range(0, 3))
         0: return ($urandom_range(0, 1) != 0) ? 8'hFF - 8'($urandom_range(0, 1))
                                               : 8'($urandom_range(0, 1));
         1: return 8'($urandom_range(0, 3));   // crowd equal priorities
         2: return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(8'h78, 8'h88));
      endcase
   endfunction

   task automatic run_mixed(int len);
      int r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 9);
         if (r < 4)
            issue(KIND_CREATE, pick_priority(), 4'($urandom_range(0, 15)));
         else if (r < 7)
            issue(KIND_DESTROY, pick_priority(), 4'(sb.random_active_slot()));
         else if (r == 7)
            issue(KIND_DESTROY, pick_priority(), 4'($urandom_range(0, 15)));
         else
            issue(($urandom_range(0, 3) == 0) ? KIND_SPARE : KIND_READ, pick_priority(),
                  4'(($urandom_range(0, 1) != 0) ? sb.random_active_slot()
                                                 : $urandom_range(0, 15)));
      end
   endtask

   initial begin
      int floor_count;
      sb               = new();
      cycle_count      = 0;
      items_sent       = 0;
      burst_left       = 0;
      stall_timer      = 0;
      stall_mode       = 0;
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_READ;
      req_priority_req = '0;
      req_slot         = '0;
      rsp_ready        = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: untouched slots, ordering with ties, head and tail removal, inactive destroys
      issue(KIND_READ, 8'h00, 4'd0);
      issue(KIND_READ, 8'hFF, 4'd15);
      issue(KIND_CREATE, 8'h80, 4'd0);
      issue(KIND_CREATE, 8'h80, 4'd0);
      issue(KIND_CREATE, 8'h00, 4'd0);
      issue(KIND_CREATE, 8'hFF, 4'd0);
      issue(KIND_CREATE, 8'hFE, 4'd0);
      issue(KIND_SPARE, 8'h55, 4'd4);
      issue(KIND_DESTROY, 8'h00, 4'd2);
      issue(KIND_DESTROY, 8'h00, 4'd0);
      issue(KIND_DESTROY, 8'h00, 4'd3);
      issue(KIND_DESTROY, 8'h00, 4'd9);
      issue(KIND_DESTROY, 8'h00, 4'd2);
      issue(KIND_READ, 8'hAA, 4'd0);
      issue(KIND_READ, 8'h00, 4'd1);

      while (items_sent < RANDOM_ITEMS + 15) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               // fill to the brim, then knock on a full table
               while (sb.active_total() < TABLE_SLOTS)
                  issue(KIND_CREATE, pick_priority(), 4'($urandom_range(0, 15)));
               repeat ($urandom_range(1, 2))
                  issue(KIND_CREATE, pick_priority(), 4'($urandom_range(0, 15)));
               issue(KIND_READ, pick_priority(), 4'($urandom_range(0, 15)));
            end
            2, 3: begin
               floor_count = $urandom_range(0, 3);
               while (sb.active_total() > floor_count)
                  issue(KIND_DESTROY, pick_priority(), 4'(sb.random_active_slot()));
               issue(KIND_READ, pick_priority(), 4'($urandom_range(0, 15)));
            end
            9: repeat ($urandom_range(3, 12))
                  issue(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        4'($urandom_range(0, 15)));
            default: run_mixed($urandom_range(10, 40));
         endcase
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.errors += sb.pending();
      if (sb.errors == 0)
         $display("priority_ordered_task_table_tb: done, clean");
      else
         $display("priority_ordered_task_table_tb: done, errors");
      $finish;
   end
endmodule

@@ priority_ordered_task_table.f @@
+incdir+sv
sv/pott_pkg.sv
sv/pott_ram.sv
sv/priority_ordered_task_table.sv
verif/priority_ordered_task_table_tb.sv
